// ----- sv/circle_point_generator_top_macros.svh -----
// Assertion macros for the circle point generator checker.
`ifndef CIRCLE_POINT_GENERATOR_TOP_MACROS_SVH
`define CIRCLE_POINT_GENERATOR_TOP_MACROS_SVH

// Clocked assertion, disabled while reset is asserted.
`define CPG_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Same, with an explicit enable term ahead of the implication.
`define CPG_ASSERT_WHEN(lbl, cond, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (prop)) \
		else $error(msg);

`endif

// ----- sv/cpg_pkg.sv -----
// Shared constants and types of the circle point generator.
package cpg_pkg;

	localparam int COORD_BITS_DEF = 10;
	localparam int QUEUE_DEPTH    = 2;

	typedef enum logic {
		CMD_START = 1'b0,
		CMD_STEP  = 1'b1
	} cmd_t;

	// Order of the eight symmetric points of one step.
	typedef enum logic [2:0] {
		PT_XP_YP = 3'd0,  // (cx+x, cy+y)
		PT_XP_YM = 3'd1,  // (cx+x, cy-y)
		PT_YP_XP = 3'd2,  // (cx+y, cy+x)
		PT_YP_XM = 3'd3,  // (cx+y, cy-x)
		PT_YM_XP = 3'd4,  // (cx-y, cy+x)
		PT_YM_XM = 3'd5,  // (cx-y, cy-x)
		PT_XM_YP = 3'd6,  // (cx-x, cy+y)
		PT_XM_YM = 3'd7   // (cx-x, cy-y)
	} pt_t;

	typedef struct packed {
		logic full;
		logic valid;
	} q_status_t;

endpackage

// ----- sv/cpg_front.sv -----
// Front end: takes commands, runs the Bresenham recurrence, queues one record per step.
module cpg_front #(
	parameter int COORD_BITS = cpg_pkg::COORD_BITS_DEF,
	parameter int REC_W      = 4 * COORD_BITS + 5
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cmd_valid,
	output logic                  cmd_stall,
	input  logic                  command,
	input  logic [COORD_BITS-1:0] center_x,
	input  logic [COORD_BITS-1:0] center_y,
	input  logic [COORD_BITS-1:0] radius,
	input  cpg_pkg::q_status_t    q_status,
	output logic                  push,
	output logic [REC_W-1:0]      push_rec
);
	import cpg_pkg::*;

	localparam int PW = COORD_BITS + 2;  // x, y
	localparam int DW = COORD_BITS + 4;  // decision value

	logic                  active_q;
	logic signed [PW-1:0]  cur_x_q, cur_y_q;
	logic signed [DW-1:0]  dec_q;
	logic [COORD_BITS-1:0] cx_q, cy_q;

	logic                  accept;
	logic signed [PW-1:0]  x_nxt, y_nxt;
	logic signed [DW-1:0]  dec_nxt, x_ext, y_ext;
	logic                  done;

	assign cmd_stall = q_status.full;
	assign accept    = cmd_valid && !cmd_stall;
	assign push      = accept && (cmd_t'(command) == CMD_STEP) && active_q;

	assign x_ext = DW'(cur_x_q);
	assign y_ext = DW'(cur_y_q);

	always_comb begin
		x_nxt = cur_x_q + PW'(1);
		if (dec_q < 0) begin
			dec_nxt = dec_q + (x_ext <<< 2) + DW'(6);
			y_nxt   = cur_y_q;
		end else begin
			dec_nxt = dec_q + ((x_ext - y_ext) <<< 2) + DW'(10);
			y_nxt   = cur_y_q - PW'(1);
		end
		done = x_nxt > y_nxt;
	end

	assign push_rec = {cx_q, cy_q, cur_x_q, cur_y_q, done};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			cur_x_q  <= '0;
			cur_y_q  <= '0;
			dec_q    <= '0;
			cx_q     <= '0;
			cy_q     <= '0;
		end else if (accept) begin
			if (cmd_t'(command) == CMD_START) begin
				active_q <= 1'b1;
				cx_q     <= center_x;
				cy_q     <= center_y;
				cur_x_q  <= '0;
				cur_y_q  <= PW'(radius);
				dec_q    <= DW'(3) - (DW'(radius) <<< 1);
			end else if (active_q) begin
				cur_x_q  <= x_nxt;
				cur_y_q  <= y_nxt;
				dec_q    <= dec_nxt;
				active_q <= !done;
			end
		end
	end

endmodule

// ----- sv/cpg_queue.sv -----
// Small register queue of step records between front and back end.
module cpg_queue #(
	parameter int WIDTH = 45,
	parameter int DEPTH = cpg_pkg::QUEUE_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  logic [WIDTH-1:0]   push_data,
	input  logic               pop,
	output logic [WIDTH-1:0]   pop_data,
	output cpg_pkg::q_status_t status
);
	import cpg_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [WIDTH-1:0]  mem_q [DEPTH];
	logic [AW-1:0]     wr_q, rd_q;
	logic [AW:0]       cnt_q;
	logic              do_push, do_pop;

	assign status.full  = (cnt_q == (AW+1)'(DEPTH));
	assign status.valid = (cnt_q != '0);
	assign do_push      = push && !status.full;
	assign do_pop       = pop && status.valid;
	assign pop_data     = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + AW'(1);
			end
			if (do_pop) begin
				rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + AW'(1);
			end
			cnt_q <= cnt_q + (AW+1)'(do_push) - (AW+1)'(do_pop);
		end
	end

endmodule

// ----- sv/cpg_back.sv -----
// Back end: expands one step record into eight points through an output register.
module cpg_back #(
	parameter int COORD_BITS = cpg_pkg::COORD_BITS_DEF,
	parameter int REC_W      = 4 * COORD_BITS + 5
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  cpg_pkg::q_status_t           q_status,
	input  logic [REC_W-1:0]             pop_rec,
	output logic                         pop,
	output logic                         pix_valid,
	input  logic                         pix_stall,
	output logic signed [COORD_BITS+1:0] pixel_x,
	output logic signed [COORD_BITS+1:0] pixel_y,
	output logic                         last_of_step,
	output logic                         last_of_circle
);
	import cpg_pkg::*;

	localparam int PW = COORD_BITS + 2;

	logic [REC_W-1:0]     rec_q;
	logic                 have_q;
	pt_t                  idx_q;
	logic                 valid_q;
	logic signed [PW-1:0] px_q, py_q;
	logic                 lstep_q, lcirc_q;

	logic signed [PW-1:0] cx, cy, x, y, px, py;
	logic                 done, out_ok, emit, final_pt;

	assign cx   = PW'(rec_q[REC_W-1 -: COORD_BITS]);
	assign cy   = PW'(rec_q[REC_W-COORD_BITS-1 -: COORD_BITS]);
	assign x    = rec_q[2*PW:PW+1];
	assign y    = rec_q[PW:1];
	assign done = rec_q[0];

	assign out_ok   = !valid_q || !pix_stall;
	assign emit     = have_q && out_ok;
	assign final_pt = (idx_q == PT_XM_YM);
	assign pop      = q_status.valid && (!have_q || (emit && final_pt));

	always_comb begin
		unique case (idx_q)
			PT_XP_YP: begin px = cx + x; py = cy + y; end
			PT_XP_YM: begin px = cx + x; py = cy - y; end
			PT_YP_XP: begin px = cx + y; py = cy + x; end
			PT_YP_XM: begin px = cx + y; py = cy - x; end
			PT_YM_XP: begin px = cx - y; py = cy + x; end
			PT_YM_XM: begin px = cx - y; py = cy - x; end
			PT_XM_YP: begin px = cx - x; py = cy + y; end
			PT_XM_YM: begin px = cx - x; py = cy - y; end
			default:  begin px = cx;     py = cy;     end
		endcase
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			rec_q <= pop_rec;
		end
		if (emit) begin
			px_q    <= px;
			py_q    <= py;
			lstep_q <= final_pt;
			lcirc_q <= final_pt && done;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_q  <= 1'b0;
			idx_q   <= PT_XP_YP;
			valid_q <= 1'b0;
		end else begin
			if (emit) begin
				valid_q <= 1'b1;
				idx_q   <= pt_t'(idx_q + 3'd1);
				if (final_pt) begin
					have_q <= 1'b0;
				end
			end else if (out_ok) begin
				valid_q <= 1'b0;
			end
			// a new record wins over the end of the previous one
			if (pop) begin
				have_q <= 1'b1;
				idx_q  <= PT_XP_YP;
			end
		end
	end

	assign pix_valid      = valid_q;
	assign pixel_x        = px_q;
	assign pixel_y        = py_q;
	assign last_of_step   = lstep_q;
	assign last_of_circle = lcirc_q;

endmodule

// ----- sv/circle_point_generator_top.sv -----
// Top level of the Bresenham circle point generator.
//
//   channel  direction  handshake             payload
//   cmd      in         cmd_valid/cmd_stall   command, center_x, center_y, radius
//   pix      out        pix_valid/pix_stall   pixel_x, pixel_y, last_of_step, last_of_circle
//
// A start item is absorbed by the front; a step item is taken and queued, and the
// back end then drives one point per cycle while pix_stall is low, eight per step.
// Sustained step rate is set by the single output port, which emits eight points per step.
// The two-entry step queue lets the front take items while points still drain.
// Reset clears the generator to idle; a stalled pix item holds until taken.
module circle_point_generator_top #(
	parameter int COORD_BITS = cpg_pkg::COORD_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cmd_valid,
	output logic                         cmd_stall,
	input  logic                         command,
	input  logic [COORD_BITS-1:0]        center_x,
	input  logic [COORD_BITS-1:0]        center_y,
	input  logic [COORD_BITS-1:0]        radius,
	output logic                         pix_valid,
	input  logic                         pix_stall,
	output logic signed [COORD_BITS+1:0] pixel_x,
	output logic signed [COORD_BITS+1:0] pixel_y,
	output logic                         last_of_step,
	output logic                         last_of_circle
);
	import cpg_pkg::*;

	localparam int REC_W = 4 * COORD_BITS + 5;

	q_status_t        q_status;
	logic             push, pop;
	logic [REC_W-1:0] push_rec, pop_rec;

	cpg_front #(
		.COORD_BITS (COORD_BITS),
		.REC_W      (REC_W)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.command   (command),
		.center_x  (center_x),
		.center_y  (center_y),
		.radius    (radius),
		.q_status  (q_status),
		.push      (push),
		.push_rec  (push_rec)
	);

	cpg_queue #(
		.WIDTH (REC_W),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_rec),
		.pop       (pop),
		.pop_data  (pop_rec),
		.status    (q_status)
	);

	cpg_back #(
		.COORD_BITS (COORD_BITS),
		.REC_W      (REC_W)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.q_status       (q_status),
		.pop_rec        (pop_rec),
		.pop            (pop),
		.pix_valid      (pix_valid),
		.pix_stall      (pix_stall),
		.pixel_x        (pixel_x),
		.pixel_y        (pixel_y),
		.last_of_step   (last_of_step),
		.last_of_circle (last_of_circle)
	);

endmodule

// ----- sv/cpg_checker.sv -----
// Port-level checker for the circle point generator, bound to the top level.
`include "circle_point_generator_top_macros.svh"

module cpg_checker #(
	parameter int COORD_BITS = cpg_pkg::COORD_BITS_DEF
) (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         pix_valid,
	input logic                         pix_stall,
	input logic signed [COORD_BITS+1:0] pixel_x,
	input logic signed [COORD_BITS+1:0] pixel_y,
	input logic                         last_of_step,
	input logic                         last_of_circle
);
	import cpg_pkg::*;

	logic pix_take;
	assign pix_take = pix_valid && !pix_stall;

	`CPG_ASSERT(a_valid_holds, pix_valid && pix_stall |=> pix_valid, "pix item dropped while stalled")
	`CPG_ASSERT(a_payload_holds, pix_valid && pix_stall |=> $stable(pixel_x) && $stable(pixel_y), "pix payload moved while stalled")
	`CPG_ASSERT_WHEN(a_circle_ends_step, pix_valid && last_of_circle, last_of_step, "circle end not on last point of step")
	`CPG_ASSERT(a_step_spacing, pix_take && last_of_step |=> !(pix_valid && last_of_step), "step end followed directly by another step end")

endmodule

bind circle_point_generator_top cpg_checker #(
	.COORD_BITS (COORD_BITS)
) u_cpg_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.pix_valid      (pix_valid),
	.pix_stall      (pix_stall),
	.pixel_x        (pixel_x),
	.pixel_y        (pixel_y),
	.last_of_step   (last_of_step),
	.last_of_circle (last_of_circle)
);
